// ----- rtl/hamming_ratio_test_matcher_core_assert.svh -----
// Assertion macros for the matcher RTL, included by hrtm_queue.
// Each one samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef HAMMING_RATIO_TEST_MATCHER_CORE_ASSERT_SVH
`define HAMMING_RATIO_TEST_MATCHER_CORE_ASSERT_SVH

// The property must hold at every sampled edge.
`define HRTM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a sampled edge.
`define HRTM_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/hrtm_pkg.sv -----
package hrtm_pkg;

    localparam int DESC_WORDS      = 4;
    localparam int WORD_WIDTH      = 64;
    localparam int INDEX_WIDTH     = 12;
    localparam int IN_LEVEL_WIDTH  = 3;
    localparam int LEVEL_WIDTH     = 4;
    localparam int DIST_WIDTH      = 9;
    localparam int CNT_WIDTH       = 7;
    localparam int LEVEL_COUNT     = 8;
    localparam int CFG_DATA_WIDTH  = 9;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);

    localparam int INDEX_LSB       = DESC_WORDS * WORD_WIDTH;
    localparam int LEVEL_LSB       = INDEX_LSB + INDEX_WIDTH;
    localparam int IN_DATA_WIDTH   = 272;
    localparam int OUT_DATA_WIDTH  = 32;
    localparam int PROD_WIDTH      = 2 * DIST_WIDTH;

    localparam logic [LEVEL_WIDTH-1:0]    NO_LEVEL           = 4'd15;
    localparam logic [DIST_WIDTH-1:0]     NO_DIST            = 9'd256;
    localparam logic [CFG_DATA_WIDTH-1:0] MAX_DISTANCE_RESET = 9'd100;
    localparam logic [CFG_DATA_WIDTH-1:0] RATIO_RESET        = 9'd154;

    localparam logic OP_QUERY     = 1'b0;
    localparam logic OP_CANDIDATE = 1'b1;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MAX_DISTANCE = 2'd0,
        REG_RATIO_Q8     = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic                   op;
        logic                   last;
        logic [INDEX_WIDTH-1:0] index;
        logic [LEVEL_WIDTH-1:0] level;
        logic [DIST_WIDTH-1:0]  ham_dist;
    } hrtm_item_t;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + {3'b000, v[i]};
        end
        return c;
    endfunction

    function automatic logic [CNT_WIDTH-1:0] pop64(input logic [WORD_WIDTH-1:0] v);
        logic [CNT_WIDTH-1:0] c;
        c = '0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + {3'b000, pop8(v[8*i +: 8])};
        end
        return c;
    endfunction

endpackage

// ----- rtl/hrtm_front.sv -----
module hrtm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // desc_word0, desc_word1, desc_word2, desc_word3, cand_index, cand_level, pad
    input  logic [hrtm_pkg::IN_DATA_WIDTH-1:0] s_tdata,
    // op
    input  logic                               s_tuser,
    input  logic                               s_tlast,
    output logic                               push_valid,
    input  logic                               push_ready,
    output hrtm_pkg::hrtm_item_t               push_item
);
    import hrtm_pkg::*;

    logic [WORD_WIDTH-1:0]  query_reg [DESC_WORDS];
    logic [CNT_WIDTH-1:0]   cnt_reg   [DESC_WORDS];
    logic [CNT_WIDTH-1:0]   cnt_next  [DESC_WORDS];
    logic                   st_valid_reg;
    logic                   st_valid_next;
    logic                   st_op_reg;
    logic                   st_last_reg;
    logic [INDEX_WIDTH-1:0] st_index_reg;
    logic [LEVEL_WIDTH-1:0] st_level_reg;
    logic [LEVEL_WIDTH-1:0] level_sat;
    logic [LEVEL_WIDTH-1:0] level_ext;
    logic [DIST_WIDTH-1:0]  dist_sum;
    logic                   accept;

    assign s_tready = !st_valid_reg || push_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        for (int w = 0; w < DESC_WORDS; w++)
        begin
            cnt_next[w] = pop64(query_reg[w] ^ s_tdata[w*WORD_WIDTH +: WORD_WIDTH]);
        end
    end

    assign level_ext = {1'b0, s_tdata[LEVEL_LSB +: IN_LEVEL_WIDTH]};
    assign level_sat = (level_ext >= LEVEL_WIDTH'(LEVEL_COUNT)) ?
                       LEVEL_WIDTH'(LEVEL_COUNT - 1) : level_ext;

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (accept)
        begin
            st_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
            for (int w = 0; w < DESC_WORDS; w++)
            begin
                query_reg[w] <= '0;
            end
        end
        else
        begin
            st_valid_reg <= st_valid_next;
            if (accept && s_tuser == OP_QUERY)
            begin
                for (int w = 0; w < DESC_WORDS; w++)
                begin
                    query_reg[w] <= s_tdata[w*WORD_WIDTH +: WORD_WIDTH];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_op_reg    <= s_tuser;
            st_last_reg  <= s_tlast;
            st_index_reg <= s_tdata[INDEX_LSB +: INDEX_WIDTH];
            st_level_reg <= level_sat;
            for (int w = 0; w < DESC_WORDS; w++)
            begin
                cnt_reg[w] <= cnt_next[w];
            end
        end
    end

    always_comb
    begin
        dist_sum = '0;
        for (int w = 0; w < DESC_WORDS; w++)
        begin
            dist_sum = dist_sum + DIST_WIDTH'(cnt_reg[w]);
        end
    end

    assign push_valid         = st_valid_reg;
    assign push_item.op       = st_op_reg;
    assign push_item.last     = st_last_reg;
    assign push_item.index    = st_index_reg;
    assign push_item.level    = st_level_reg;
    assign push_item.ham_dist = dist_sum;

endmodule

// ----- rtl/hrtm_queue.sv -----
module hrtm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  hrtm_pkg::hrtm_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output hrtm_pkg::hrtm_item_t pop_item
);
    import hrtm_pkg::*;

    `include "hamming_ratio_test_matcher_core_assert.svh"

    hrtm_item_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg;
    logic [QPTR_WIDTH-1:0] wr_ptr_next;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg;
    logic [QPTR_WIDTH-1:0] rd_ptr_next;
    logic [QPTR_WIDTH:0]   count_reg;
    logic [QPTR_WIDTH:0]   count_next;
    logic                  push;
    logic                  pop;

    assign push_ready = count_reg != (QPTR_WIDTH+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `HRTM_ASSERT(a_count_bound, count_reg <= (QPTR_WIDTH+1)'(QUEUE_DEPTH), "queue overfilled")
    `HRTM_ASSERT(a_ptr_span, wr_ptr_reg == QPTR_WIDTH'(rd_ptr_reg + count_reg), "pointer skew")
    `HRTM_ASSERT(a_push_grow, (push && !pop) |=> count_reg == $past(count_reg) + 1'b1, "push lost")
    `HRTM_ASSERT_NEVER(a_pop_empty, pop_ready && !pop_valid && pop, "pop from empty queue")

endmodule

// ----- rtl/hrtm_back.sv -----
module hrtm_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [hrtm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [hrtm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                                 pop_valid,
    output logic                                 pop_ready,
    input  hrtm_pkg::hrtm_item_t                 pop_item,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // matched, best_index, best_distance, second_distance, pad
    output logic [hrtm_pkg::OUT_DATA_WIDTH-1:0]  m_tdata
);
    import hrtm_pkg::*;

    logic [CFG_DATA_WIDTH-1:0] max_dist_reg;
    logic [CFG_DATA_WIDTH-1:0] ratio_reg;

    logic [DIST_WIDTH-1:0]  best_reg,     best_next;
    logic [DIST_WIDTH-1:0]  second_reg,   second_next;
    logic [LEVEL_WIDTH-1:0] best_lvl_reg, best_lvl_next;
    logic [LEVEL_WIDTH-1:0] sec_lvl_reg,  sec_lvl_next;
    logic [INDEX_WIDTH-1:0] idx_reg,      idx_next;

    logic [DIST_WIDTH-1:0]  upd_best, upd_second;
    logic [LEVEL_WIDTH-1:0] upd_best_lvl, upd_sec_lvl;
    logic [INDEX_WIDTH-1:0] upd_idx;

    logic                   fin_valid_reg, fin_valid_next;
    logic [DIST_WIDTH-1:0]  fin_best_reg, fin_second_reg;
    logic [LEVEL_WIDTH-1:0] fin_best_lvl_reg, fin_sec_lvl_reg;
    logic [INDEX_WIDTH-1:0] fin_idx_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [OUT_DATA_WIDTH-1:0] out_data_reg;

    logic                  out_ready;
    logic                  fin_ready;
    logic                  pop;
    logic                  finish;
    logic                  matched;
    logic [PROD_WIDTH-1:0] lhs;
    logic [PROD_WIDTH-1:0] rhs;

    assign out_ready = !out_valid_reg || m_tready;
    assign fin_ready = !fin_valid_reg || out_ready;
    assign pop_ready = fin_ready;
    assign pop       = pop_valid && pop_ready;
    assign finish    = pop && pop_item.op == OP_CANDIDATE && pop_item.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= MAX_DISTANCE_RESET;
            ratio_reg    <= RATIO_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MAX_DISTANCE: max_dist_reg <= cfg_data;
                REG_RATIO_Q8:     ratio_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        upd_best     = best_reg;
        upd_second   = second_reg;
        upd_best_lvl = best_lvl_reg;
        upd_sec_lvl  = sec_lvl_reg;
        upd_idx      = idx_reg;
        if (pop_item.ham_dist < best_reg)
        begin
            upd_second   = best_reg;
            upd_sec_lvl  = best_lvl_reg;
            upd_best     = pop_item.ham_dist;
            upd_best_lvl = pop_item.level;
            upd_idx      = pop_item.index;
        end
        else if (pop_item.ham_dist < second_reg)
        begin
            upd_second  = pop_item.ham_dist;
            upd_sec_lvl = pop_item.level;
        end
    end

    always_comb
    begin
        best_next     = best_reg;
        second_next   = second_reg;
        best_lvl_next = best_lvl_reg;
        sec_lvl_next  = sec_lvl_reg;
        idx_next      = idx_reg;
        if (pop)
        begin
            if (pop_item.op == OP_QUERY || pop_item.last)
            begin
                best_next     = NO_DIST;
                second_next   = NO_DIST;
                best_lvl_next = NO_LEVEL;
                sec_lvl_next  = NO_LEVEL;
                idx_next      = '0;
            end
            else
            begin
                best_next     = upd_best;
                second_next   = upd_second;
                best_lvl_next = upd_best_lvl;
                sec_lvl_next  = upd_sec_lvl;
                idx_next      = upd_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg     <= NO_DIST;
            second_reg   <= NO_DIST;
            best_lvl_reg <= NO_LEVEL;
            sec_lvl_reg  <= NO_LEVEL;
            idx_reg      <= '0;
        end
        else
        begin
            best_reg     <= best_next;
            second_reg   <= second_next;
            best_lvl_reg <= best_lvl_next;
            sec_lvl_reg  <= sec_lvl_next;
            idx_reg      <= idx_next;
        end
    end

    assign fin_valid_next = fin_ready ? finish : fin_valid_reg;

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            fin_best_reg     <= upd_best;
            fin_second_reg   <= upd_second;
            fin_best_lvl_reg <= upd_best_lvl;
            fin_sec_lvl_reg  <= upd_sec_lvl;
            fin_idx_reg      <= upd_idx;
        end
    end

    assign lhs = {1'b0, fin_best_reg, 8'h00};
    assign rhs = PROD_WIDTH'(ratio_reg) * PROD_WIDTH'(fin_second_reg);

    always_comb
    begin
        matched = fin_best_lvl_reg != NO_LEVEL && fin_best_reg <= max_dist_reg;
        if (fin_best_lvl_reg == fin_sec_lvl_reg && lhs > rhs)
        begin
            matched = 1'b0;
        end
    end

    assign out_valid_next = out_ready ? fin_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && fin_valid_reg)
        begin
            out_data_reg <= {1'b0, fin_second_reg, fin_best_reg, fin_idx_reg, matched};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- rtl/hamming_ratio_test_matcher_core.sv -----
// Hamming nearest-neighbor matcher with ratio test for 256-bit binary descriptors.
// Input stream: tuser is op (0 loads the query, 1 presents a candidate), tlast marks
// the final candidate of a query, tdata carries the four descriptor words, the
// candidate index and its pyramid level.
// Output stream: one item per last candidate with matched, best_index, best_distance
// and second_distance.
// Config channel: index 0 writes max_distance, index 1 writes ratio_q8; always ready.
// Write it only while no item is in flight.
// Throughput: one item per cycle unless stalled, set by the best/second compare.
// Path: the last candidate passes the popcount stage register, the queue, best
// tracking into the finish registers, then the ratio multiply into the output reg.
// A four-entry queue parts the popcount front from the tracking back; when the
// receiver stalls, the result holds in the output register and input keeps flowing
// until the queue fills, then tready drops.
// Reset clears the query to zero, the running search to "none", and the registers to
// max_distance 100 and ratio_q8 154.
module hamming_ratio_test_matcher_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // desc_word0, desc_word1, desc_word2, desc_word3, cand_index, cand_level, pad
    input  logic [hrtm_pkg::IN_DATA_WIDTH-1:0]   s_tdata,
    // op
    input  logic                                 s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // matched, best_index, best_distance, second_distance, pad
    output logic [hrtm_pkg::OUT_DATA_WIDTH-1:0]  m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hrtm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [hrtm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import hrtm_pkg::*;

    logic       push_valid;
    logic       push_ready;
    hrtm_item_t push_item;
    logic       pop_valid;
    logic       pop_ready;
    hrtm_item_t pop_item;

    assign cfg_ready = 1'b1;

    hrtm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    hrtm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    hrtm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
